### rtl/core/knn_distance_top_k_top_assert.svh
// Assertion macros for the k-nearest-neighbor ranking block.
// Clocked on i_clk and disabled while i_rst_n is low.
`ifndef KNN_DISTANCE_TOP_K_TOP_ASSERT_SVH
`define KNN_DISTANCE_TOP_K_TOP_ASSERT_SVH

// Same-cycle implication.
`define KNN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("knn assertion failed");

// Next-cycle implication.
`define KNN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("knn assertion failed");

`endif

### rtl/core/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants, codes and types of the k-nearest-neighbor ranking block.
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int MAX_K       = 8;
    localparam int ELEM_W      = 16;
    localparam int LABEL_W     = 8;
    localparam int DIST_W      = 48;
    localparam int CNT_W       = 16;
    localparam int VL_W        = 11;
    localparam int KIN_W       = 4;
    localparam int RANK_W      = 3;
    localparam int KE_W        = $clog2(MAX_K + 1);
    localparam int RI_W        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 80;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [DIST_W-1:0] INFINITY = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [VL_W-1:0]  VL_RESET = VL_W'(1024);
    localparam logic [KIN_W-1:0] K_RESET  = KIN_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE      = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_REPORT = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic              q_write;
        logic              capture;
        logic              square;
        logic              accum;
        logic              finish;
        logic              report;
        logic              clear;
        logic [RI_W-1:0]   rank;
        logic              rank_last;
    } t_cmd;

endpackage

### rtl/core/knn_datapath.sv
// ----------------------------------------------------------------------------
// knn_datapath
// Query memory, squared-difference accumulator, top-K list and result register.
// ----------------------------------------------------------------------------
module knn_datapath import knn_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [ELEM_W-1:0]   i_value,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic                i_last,
    input  logic [VL_W-1:0]     i_vector_length,
    input  logic [KE_W-1:0]     i_k_eff,
    output logic                o_kind,
    output logic                o_status,
    output logic [RANK_W-1:0]   o_rank,
    output logic [LABEL_W-1:0]  o_label,
    output logic [DIST_W-1:0]   o_distance,
    output logic                o_filled,
    output logic [CNT_W-1:0]    o_samples,
    output logic                o_end
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [ELEM_W-1:0]  r_qmem [MAX_LEN];
    logic [ELEM_W-1:0]  r_qrd;
    logic [AW-1:0]      r_qidx;
    logic [CW-1:0]      r_cnt;
    logic [DIST_W-1:0]  r_acc;
    logic [ELEM_W-1:0]  r_val;
    logic [LABEL_W-1:0] r_lbl;
    logic [2*ELEM_W+1:0] r_sq;

    logic [DIST_W-1:0]  r_best_d [MAX_K];
    logic [LABEL_W-1:0] r_best_l [MAX_K];
    logic [MAX_K-1:0]   r_best_f;
    logic [CNT_W-1:0]   r_count;

    logic [DIST_W-1:0]  n_best_d [MAX_K];
    logic [LABEL_W-1:0] n_best_l [MAX_K];
    logic [MAX_K-1:0]   n_best_f;
    logic [MAX_K-1:0]   w_lt;
    logic [MAX_K-1:0]   w_after;
    logic               w_enter;
    logic               w_ok;
    logic [CNT_W-1:0]   n_count;
    logic signed [ELEM_W:0] w_diff;
    logic [ELEM_W:0]    w_mag;
    logic [DIST_W:0]    w_sum;

    assign w_diff = $signed({r_val[ELEM_W-1], r_val}) - $signed({r_qrd[ELEM_W-1], r_qrd});
    assign w_mag  = w_diff[ELEM_W] ? (ELEM_W+1)'(-w_diff) : w_diff;
    assign w_sum  = {1'b0, r_acc} + (DIST_W+1)'(r_sq);

    assign w_ok = (i_vector_length != '0)
               && (32'(i_vector_length) <= 32'(MAX_LEN))
               && (32'(r_cnt) == 32'(i_vector_length));

    assign n_count = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;

    // parallel compare and shift insert
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            w_lt[i] = r_acc < r_best_d[i];
        end
        w_enter = w_lt[RI_W'(i_k_eff - 1'b1)];
        for (int i = 0; i < MAX_K; i++) begin
            w_after[i] = w_lt[i] || (32'(i) >= 32'(i_k_eff) - 1);
            if (i > 0) begin
                w_after[i] = w_after[i] || w_after[i-1];
            end
        end
        for (int i = 0; i < MAX_K; i++) begin
            n_best_d[i] = r_best_d[i];
            n_best_l[i] = r_best_l[i];
            n_best_f[i] = r_best_f[i];
            if (w_enter && (32'(i) < 32'(i_k_eff)) && w_after[i]) begin
                if (i > 0 && w_after[i-1]) begin
                    n_best_d[i] = r_best_d[i-1];
                    n_best_l[i] = r_best_l[i-1];
                    n_best_f[i] = r_best_f[i-1];
                end else begin
                    n_best_d[i] = r_acc;
                    n_best_l[i] = r_lbl;
                    n_best_f[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_write) begin
            r_qmem[r_qidx] <= i_value;
        end
        if (i_cmd.capture) begin
            r_qrd <= r_qmem[r_cnt[AW-1:0]];
            r_val <= i_value;
            r_lbl <= i_label;
        end
        if (i_cmd.square) begin
            r_sq <= (2*ELEM_W+2)'(w_mag * w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qidx  <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_count <= '0;
            r_best_f <= '0;
            for (int i = 0; i < MAX_K; i++) begin
                r_best_d[i] <= INFINITY;
                r_best_l[i] <= '0;
            end
        end else begin
            if (i_cmd.q_write) begin
                if (i_last || (32'(r_qidx) == MAX_LEN - 1)) begin
                    r_qidx <= '0;
                end else begin
                    r_qidx <= r_qidx + 1'b1;
                end
            end
            if (i_cmd.accum && (32'(r_cnt) < 32'(MAX_LEN))) begin
                r_acc <= w_sum[DIST_W] ? INFINITY : w_sum[DIST_W-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.finish) begin
                r_cnt <= '0;
                r_acc <= '0;
                if (w_ok) begin
                    r_count <= n_count;
                    r_best_d <= n_best_d;
                    r_best_l <= n_best_l;
                    r_best_f <= n_best_f;
                end
            end
            if (i_cmd.clear) begin
                r_count  <= '0;
                r_best_f <= '0;
                for (int i = 0; i < MAX_K; i++) begin
                    r_best_d[i] <= INFINITY;
                    r_best_l[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_kind     <= 1'b0;
            o_status   <= !w_ok;
            o_rank     <= '0;
            o_label    <= w_ok ? r_lbl : '0;
            o_distance <= w_ok ? r_acc : '0;
            o_filled   <= 1'b0;
            o_samples  <= w_ok ? n_count : r_count;
            o_end      <= 1'b1;
        end else if (i_cmd.report) begin
            o_kind     <= 1'b1;
            o_status   <= 1'b0;
            o_rank     <= RANK_W'(i_cmd.rank);
            o_label    <= r_best_l[i_cmd.rank];
            o_distance <= r_best_d[i_cmd.rank];
            o_filled   <= r_best_f[i_cmd.rank];
            o_samples  <= r_count;
            o_end      <= i_cmd.rank_last;
        end
    end

endmodule

### rtl/core/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl
// Sequencer: request intake, sample element steps, result emission.
// ----------------------------------------------------------------------------
module knn_ctrl import knn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [1:0]       i_op,
    input  logic             i_last,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  logic [KE_W-1:0]  i_k_eff,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_FINISH,
        S_REPORT
    } t_state;

    t_state          r_state;
    logic [RI_W-1:0] r_rank;
    logic            r_last;
    logic            r_out_valid;
    logic            w_acc;
    logic            w_free;
    t_op             w_op;

    assign w_op       = t_op'(i_op);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_free     = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.rank      = r_rank;
        o_cmd.rank_last = (KE_W'(r_rank) == i_k_eff - 1'b1);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.q_write = (w_op == OP_LOAD);
                    o_cmd.capture = (w_op == OP_SAMPLE);
                    o_cmd.clear   = (w_op == OP_CLEAR);
                end
            end
            S_SQUARE: o_cmd.square = 1'b1;
            S_ACCUM:  o_cmd.accum  = 1'b1;
            S_FINISH: o_cmd.finish = w_free;
            S_REPORT: o_cmd.report = w_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rank      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_cmd.finish || o_cmd.report || (r_out_valid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_last <= i_last;
                        r_rank <= '0;
                        case (w_op)
                            OP_SAMPLE: r_state <= S_SQUARE;
                            OP_REPORT: r_state <= S_REPORT;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SQUARE: r_state <= S_ACCUM;
                S_ACCUM:  r_state <= r_last ? S_FINISH : S_IDLE;
                S_FINISH: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_REPORT: begin
                    if (w_free) begin
                        if (o_cmd.rank_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rank <= r_rank + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/knn_distance_top_k_top.sv
// A sample element request steps through query memory read, square and
// accumulate, a sample's last element also through a finish step; the query
// memory read and the multiplier stage are registered. Load and clear requests
// complete at intake; a report emits one result per ranked entry. Any output
// stall holds the finish and report steps. Distances are squared euclidean,
// saturating at all ones; ties keep the earlier match.
// ----------------------------------------------------------------------------
// knn_distance_top_k_top
// k-nearest-neighbor ranking by squared distance with a sorted top-K list.
// ----------------------------------------------------------------------------
module knn_distance_top_k_top import knn_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // value[15:0], sample_label[23:16]
    input  logic [1:0]             s_axis_tuser,  // op
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status[0], rank[3:1], match_label[11:4], distance[59:12], filled[60],
    // checked_count[76:61], zero fill[79:77]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tuser,  // kind
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [VL_W-1:0]  r_vector_length;
    logic [KIN_W-1:0] r_k_in_use;
    logic [KE_W-1:0]  w_k_eff;
    t_cmd             w_cmd;

    logic               w_status;
    logic [RANK_W-1:0]  w_rank;
    logic [LABEL_W-1:0] w_label;
    logic [DIST_W-1:0]  w_dist;
    logic               w_filled;
    logic [CNT_W-1:0]   w_samples;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= VL_RESET;
            r_k_in_use      <= K_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[VL_W-1:0];
                CFG_K_IN_USE:      r_k_in_use      <= i_cfg_data[KIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_k_in_use == '0) begin
            w_k_eff = KE_W'(1);
        end else if (32'(r_k_in_use) > MAX_K) begin
            w_k_eff = KE_W'(MAX_K);
        end else begin
            w_k_eff = KE_W'(r_k_in_use);
        end
    end

    knn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_op       (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_k_eff    (w_k_eff),
        .o_cmd      (w_cmd)
    );

    knn_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_value         (s_axis_tdata[15:0]),
        .i_label         (s_axis_tdata[23:16]),
        .i_last          (s_axis_tlast),
        .i_vector_length (r_vector_length),
        .i_k_eff         (w_k_eff),
        .o_kind          (m_axis_tuser),
        .o_status        (w_status),
        .o_rank          (w_rank),
        .o_label         (w_label),
        .o_distance      (w_dist),
        .o_filled        (w_filled),
        .o_samples       (w_samples),
        .o_end           (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_samples, w_filled, w_dist, w_label, w_rank, w_status};

`include "knn_distance_top_k_top_assert.svh"

    `KNN_ASSERT_SAME(a_status_ends_run, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    `KNN_ASSERT_SAME(a_skip_zero_dist, m_axis_tvalid && !m_axis_tuser && w_status, w_dist == '0)
    `KNN_ASSERT_NEXT(a_report_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_REPORT, !s_axis_tready)

endmodule
